FILE: rtl/core/brd_pkg.sv
`default_nettype none
package brd_pkg;

  // Field widths
  localparam int CH_W      = 8;
  localparam int DUTY_W    = 8;
  localparam int ELAPSED_W = 20;
  localparam int TEMP_W    = 11;
  localparam int T_W       = 9;    // clamped temperature, 0..440
  localparam int RATE_X_W  = 27;   // rate numerator / 32
  localparam int RATE_W    = 17;   // pulse rate, Q1.16
  localparam int NUM_W     = 36;   // elapsed_us * rate, and each later dividend
  localparam int REM_W     = 20;   // divider remainder, below one million
  localparam int DIG_W     = 16;   // phase step fraction digit
  localparam int DQ_W      = 17;   // one quotient digit, integer part included
  localparam int SINE_W    = 17;   // sine magnitude, Q1.16
  localparam int BNUM_W    = 22;   // brightness numerator
  localparam int BX_W      = 19;   // brightness numerator / 8
  localparam int BRIGHT_W  = 16;   // brightness, Q0.16

  // Temperature mapping (tenths of a degree)
  localparam int T_OFFSET = 100;
  localparam int T_SPAN   = 440;
  localparam int T_MID    = 220;

  // rate = floor(((9680 + 78 t) * 65536 + 22000) / 44000)
  localparam int RATE_BASE  = 9680;
  localparam int RATE_SLOPE = 78;
  localparam int RATE_BIAS  = 22000;
  // 44000 = 32 * 1375; divide by 1375 with a reciprocal, exact for x < 2^27
  localparam int RATE_SHIFT = 38;
  localparam int RATE_RECIP_W = 28;
  localparam longint unsigned RATE_RECIP =
    ((64'd1 << RATE_SHIFT) + 64'd1374) / 64'd1375;

  localparam int US_PER_S = 1000000;
  // 1e6 = 64 * 15625; divide by 15625 with a reciprocal, exact for x < 2^31
  localparam int US_SHIFT       = 6;
  localparam int US_RECIP_SHIFT = 45;
  localparam int US_RECIP_W     = 32;
  localparam longint unsigned US_RECIP =
    ((64'd1 << US_RECIP_SHIFT) + 64'd15624) / 64'd15625;

  // brightness = floor((27*65536 + 13 s) / 40), 40 = 8 * 5
  localparam int BRIGHT_BASE  = 27 * 65536;
  localparam int BRIGHT_SLOPE = 13;
  localparam int BRIGHT_SHIFT = 22;
  localparam int BRIGHT_RECIP_W = 20;
  localparam longint unsigned BRIGHT_RECIP =
    ((64'd1 << BRIGHT_SHIFT) + 64'd4) / 64'd5;

  // Sine table generation
  localparam int SINE_ONE = 65536;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SINE_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  // Datapath commands from the sequencer
  typedef struct packed {
    logic load;
    logic rate;
    logic prod;
    logic div_mul;
    logic div_sub;
    logic phase;
    logic lookup;
    logic scale;
    logic bright;
    logic out_load;
  } brd_cmd_t;

  typedef struct packed {
    logic out_free;
  } brd_sts_t;

  // Fraction digits of the phase step below the Q1.16 rate
  function automatic int phase_digits(input int phase_bits);
    return (phase_bits - 16 + DIG_W - 1) / DIG_W;
  endfunction

  // sin(pi/2 * k / 2^lg) in Q1.16, Q30 Taylor series through x^15
  function automatic logic [SINE_W-1:0] sine_q16_entry(input int unsigned k,
                                                       input int unsigned lg);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint sum;
    x    = (HALF_PI_Q30 * longint'(k)) >> lg;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      term = term / SINE_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (longint'(sum) + (64'd1 << 13)) >> 14;
    if (r > 64'd65536) begin
      r = 64'd65536;
    end
    return SINE_W'(r);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/brd_ctrl.sv
`default_nettype none
module brd_ctrl #(
  parameter int PHASE_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire brd_pkg::brd_sts_t sts,
  output brd_pkg::brd_cmd_t    cmd
);

  // integer part of the phase step first, then one 16-bit fraction digit per pass
  localparam int DIGITS = brd_pkg::phase_digits(PHASE_BITS);
  localparam int CNT_W  = 2;   // at most two fraction digits

  typedef enum logic [3:0] {
    S_IDLE,
    S_RATE,
    S_PROD,
    S_DMUL,
    S_DSUB,
    S_PHASE,
    S_LOOKUP,
    S_SCALE,
    S_BRIGHT,
    S_OUT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_RATE;
          end
        end
        S_RATE: state_r <= S_PROD;
        S_PROD: begin
          cnt_r   <= CNT_W'(DIGITS);
          state_r <= S_DMUL;
        end
        S_DMUL: state_r <= S_DSUB;
        S_DSUB: begin
          if (cnt_r == '0) begin
            state_r <= S_PHASE;
          end else begin
            cnt_r   <= cnt_r - 1'b1;
            state_r <= S_DMUL;
          end
        end
        S_PHASE:  state_r <= S_LOOKUP;
        S_LOOKUP: state_r <= S_SCALE;
        S_SCALE:  state_r <= S_BRIGHT;
        S_BRIGHT: state_r <= S_OUT;
        S_OUT: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_tvalid;
    cmd.rate     = (state_r == S_RATE);
    cmd.prod     = (state_r == S_PROD);
    cmd.div_mul  = (state_r == S_DMUL);
    cmd.div_sub  = (state_r == S_DSUB);
    cmd.phase    = (state_r == S_PHASE);
    cmd.lookup   = (state_r == S_LOOKUP);
    cmd.scale    = (state_r == S_SCALE);
    cmd.bright   = (state_r == S_BRIGHT);
    cmd.out_load = (state_r == S_OUT) && sts.out_free;
  end

endmodule
`default_nettype wire

FILE: rtl/core/brd_dp.sv
`default_nettype none
module brd_dp #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire brd_pkg::brd_cmd_t            cmd,
  output brd_pkg::brd_sts_t                 sts,
  input  wire logic [brd_pkg::CH_W-1:0]     in_red,
  input  wire logic [brd_pkg::CH_W-1:0]     in_green,
  input  wire logic [brd_pkg::CH_W-1:0]     in_blue,
  input  wire logic [brd_pkg::ELAPSED_W-1:0] in_elapsed_us,
  input  wire logic [brd_pkg::TEMP_W-1:0]   in_temp_deci_c,
  input  wire logic                         in_temp_valid,
  input  wire logic                         duty_inv,
  input  wire logic                         out_tready,
  output logic                              out_tvalid,
  output logic [brd_pkg::DUTY_W-1:0]        out_red_duty,
  output logic [brd_pkg::DUTY_W-1:0]        out_green_duty,
  output logic [brd_pkg::DUTY_W-1:0]        out_blue_duty
);

  localparam int LG     = $clog2(SINE_TABLE_DEPTH);   // depth is a power of two
  localparam int IDX_W  = LG + 1;
  localparam int DIGITS = brd_pkg::phase_digits(PHASE_BITS);
  localparam int QACC_W = brd_pkg::DQ_W + brd_pkg::DIG_W * DIGITS;
  localparam int INC_SH = brd_pkg::DIG_W * DIGITS - (PHASE_BITS - 16);
  localparam int UPROD_W = (brd_pkg::NUM_W - brd_pkg::US_SHIFT) + brd_pkg::US_RECIP_W;
  localparam int RPROD_W = brd_pkg::RATE_X_W + brd_pkg::RATE_RECIP_W;
  localparam int BPROD_W = brd_pkg::BX_W + brd_pkg::BRIGHT_RECIP_W;
  localparam int CPROD_W = brd_pkg::CH_W + brd_pkg::BRIGHT_W;

  // Quarter-wave sine table, constant
  logic [brd_pkg::SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    if (k == SINE_TABLE_DEPTH) begin : g_top
      assign sine_rom[k] = brd_pkg::SINE_W'(brd_pkg::SINE_ONE);
    end else begin : g_ent
      assign sine_rom[k] = brd_pkg::sine_q16_entry(k, LG);
    end
  end

  // Registers
  logic [brd_pkg::CH_W-1:0]      red_r, green_r, blue_r;
  logic [brd_pkg::ELAPSED_W-1:0] elapsed_r;
  logic [brd_pkg::RATE_X_W-1:0]  rate_x_r;
  logic [brd_pkg::RATE_W-1:0]    rate_r;
  logic [brd_pkg::NUM_W-1:0]     num_r;
  logic [brd_pkg::DQ_W-1:0]      dq_r;
  logic [QACC_W-1:0]             quo_r;
  logic [PHASE_BITS-1:0]         phase_r;
  logic [1:0]                    quad_r;
  logic [brd_pkg::SINE_W-1:0]    sine_r;
  logic [brd_pkg::BX_W-1:0]      bx_r;
  logic [brd_pkg::BRIGHT_W-1:0]  bright_r;
  logic                          out_valid_r;
  logic [brd_pkg::DUTY_W-1:0]    red_duty_r, green_duty_r, blue_duty_r;

  // Temperature to rate numerator
  logic [brd_pkg::TEMP_W:0]      temp_ofs;
  logic [brd_pkg::T_W-1:0]       t_val;
  logic [15:0]                   rate_lin;
  logic [31:0]                   rate_num;

  always_comb begin
    temp_ofs = {in_temp_deci_c[brd_pkg::TEMP_W-1], in_temp_deci_c}
             + (brd_pkg::TEMP_W+1)'(brd_pkg::T_OFFSET);
    if (!in_temp_valid) begin
      t_val = brd_pkg::T_W'(brd_pkg::T_MID);
    end else if (temp_ofs[brd_pkg::TEMP_W]) begin
      t_val = '0;
    end else if (temp_ofs > (brd_pkg::TEMP_W+1)'(brd_pkg::T_SPAN)) begin
      t_val = brd_pkg::T_W'(brd_pkg::T_SPAN);
    end else begin
      t_val = temp_ofs[brd_pkg::T_W-1:0];
    end
    rate_lin = 16'(brd_pkg::RATE_BASE) + 16'(brd_pkg::RATE_SLOPE) * {7'd0, t_val};
    rate_num = {rate_lin, 16'd0} + 32'(brd_pkg::RATE_BIAS);
  end

  // Reciprocal divide by 1375
  logic [RPROD_W-1:0] rate_prod;
  assign rate_prod = RPROD_W'(rate_x_r) * RPROD_W'(brd_pkg::RATE_RECIP);

  // elapsed * rate, below 2^36
  logic [brd_pkg::NUM_W-1:0] prod_w;
  assign prod_w = brd_pkg::NUM_W'(elapsed_r) * brd_pkg::NUM_W'(rate_r);

  // Divide by one million, one quotient digit per multiply/subtract pass:
  // (x >> 6) / 15625 by reciprocal, then the remainder is shifted up a digit
  logic [UPROD_W-1:0]        div_prod;
  logic [brd_pkg::REM_W-1:0] qd_lo;
  logic [brd_pkg::REM_W-1:0] rem_w;

  always_comb begin
    div_prod = UPROD_W'(num_r[brd_pkg::NUM_W-1:brd_pkg::US_SHIFT])
             * UPROD_W'(brd_pkg::US_RECIP);
    qd_lo    = brd_pkg::REM_W'(dq_r) * brd_pkg::REM_W'(brd_pkg::US_PER_S);
    rem_w    = num_r[brd_pkg::REM_W-1:0] - qd_lo;   // remainder fits in 20 bits
  end

  // Table index from phase: quadrant in the top two bits
  logic [LG-1:0]    idx_raw;
  logic [IDX_W-1:0] idx;

  always_comb begin
    idx_raw = phase_r[PHASE_BITS-3 -: LG];
    if (phase_r[PHASE_BITS-2]) begin
      idx = IDX_W'(SINE_TABLE_DEPTH) - {1'b0, idx_raw};
    end else begin
      idx = {1'b0, idx_raw};
    end
  end

  // Brightness numerator; always positive
  logic [brd_pkg::BNUM_W-1:0] bnum;
  logic [brd_pkg::BNUM_W-1:0] bsine;

  always_comb begin
    bsine = brd_pkg::BNUM_W'(sine_r) * brd_pkg::BNUM_W'(brd_pkg::BRIGHT_SLOPE);
    if (quad_r[1]) begin
      bnum = brd_pkg::BNUM_W'(brd_pkg::BRIGHT_BASE) - bsine;
    end else begin
      bnum = brd_pkg::BNUM_W'(brd_pkg::BRIGHT_BASE) + bsine;
    end
  end

  // Reciprocal divide by 5, saturate full scale
  logic [BPROD_W-1:0]             bright_prod;
  logic [brd_pkg::BRIGHT_W:0]     bright_q;
  assign bright_prod = BPROD_W'(bx_r) * BPROD_W'(brd_pkg::BRIGHT_RECIP);
  assign bright_q    = bright_prod[brd_pkg::BRIGHT_SHIFT +: brd_pkg::BRIGHT_W+1];

  // Channel scaling and polarity
  logic [CPROD_W-1:0]          red_p, green_p, blue_p;
  logic [brd_pkg::DUTY_W-1:0]  pol;

  always_comb begin
    red_p   = CPROD_W'(red_r)   * CPROD_W'(bright_r);
    green_p = CPROD_W'(green_r) * CPROD_W'(bright_r);
    blue_p  = CPROD_W'(blue_r)  * CPROD_W'(bright_r);
    pol     = {brd_pkg::DUTY_W{duty_inv}};
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      red_r     <= in_red;
      green_r   <= in_green;
      blue_r    <= in_blue;
      elapsed_r <= in_elapsed_us;
      rate_x_r  <= rate_num[31:5];
    end
    if (cmd.rate) begin
      rate_r <= rate_prod[brd_pkg::RATE_SHIFT +: brd_pkg::RATE_W];
    end
    if (cmd.prod) begin
      num_r <= prod_w;
      quo_r <= '0;
    end else if (cmd.div_sub) begin
      num_r <= {rem_w, {brd_pkg::DIG_W{1'b0}}};
      quo_r <= {quo_r[QACC_W-brd_pkg::DIG_W-1:0], {brd_pkg::DIG_W{1'b0}}}
             | QACC_W'(dq_r);
    end
    if (cmd.div_mul) begin
      dq_r <= div_prod[brd_pkg::US_RECIP_SHIFT +: brd_pkg::DQ_W];
    end
    if (cmd.lookup) begin
      sine_r <= sine_rom[idx];
      quad_r <= phase_r[PHASE_BITS-1 -: 2];
    end
    if (cmd.scale) begin
      bx_r <= bnum[brd_pkg::BNUM_W-1:3];
    end
    if (cmd.bright) begin
      bright_r <= bright_q[brd_pkg::BRIGHT_W] ? {brd_pkg::BRIGHT_W{1'b1}}
                                              : bright_q[brd_pkg::BRIGHT_W-1:0];
    end
    if (cmd.out_load) begin
      red_duty_r   <= red_p[CPROD_W-1 -: brd_pkg::DUTY_W] ^ pol;
      green_duty_r <= green_p[CPROD_W-1 -: brd_pkg::DUTY_W] ^ pol;
      blue_duty_r  <= blue_p[CPROD_W-1 -: brd_pkg::DUTY_W] ^ pol;
    end
  end

  // Phase accumulator and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.phase) begin
        phase_r <= phase_r + quo_r[INC_SH +: PHASE_BITS];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free   = !out_valid_r || out_tready;
  assign out_tvalid     = out_valid_r;
  assign out_red_duty   = red_duty_r;
  assign out_green_duty = green_duty_r;
  assign out_blue_duty  = blue_duty_r;

endmodule
`default_nettype wire

FILE: rtl/core/breathing_rgb_led_dimmer.sv
// Breathing RGB LED dimmer.
// in_*  : one update item per handshake (in_tvalid & in_tready): base color,
//         elapsed time since the last update and temperature. The temperature
//         sets a breathing rate of 0.22 to 1.0 Hz; the phase accumulator wraps.
// out_* : one duty triple per update item, held in an output register until
//         out_tready takes it.
// cfg_* : duty inversion bit (1 = 255 minus duty, for LEDs wired active low),
//         written when cfg_valid is high (cfg_ready is always high). Write it
//         only while the block is idle.
// Order: once the input is accepted, rate, product, the divide by one
//         million that turns elapsed_us * rate into a phase step (a
//         reciprocal multiply and a subtract per quotient digit, the integer
//         digit and D = ceil((PHASE_BITS - 16) / 16) fraction digits), phase,
//         table, brightness, output; the next input is taken after the output step.
// Stall: a finished item waits in the output register; the next input is
//         still accepted and worked on, and waits at the end only if the
//         previous result has not been taken yet.
// Reset: phase returns to zero, duty inversion returns to 1, no item pending.
`default_nettype none
module breathing_rgb_led_dimmer #(
  parameter int PHASE_BITS       = 32,   // 16..48
  parameter int SINE_TABLE_DEPTH = 256   // power of two, 64..4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // red[7:0], green[15:8], blue[23:16], elapsed_us[43:24],
  // temp_deci_c[54:44] (two's complement), zero pad [55]
  input  wire logic [55:0] in_tdata,
  // temp_valid[0]
  input  wire logic [0:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // red_duty[7:0], green_duty[15:8], blue_duty[23:16]
  output logic [23:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // duty_inv[0]
  input  wire logic [0:0]  cfg_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready
);

  brd_pkg::brd_cmd_t cmd;
  brd_pkg::brd_sts_t sts;

  logic       duty_inv_r;
  logic [7:0] red_duty, green_duty, blue_duty;

  // Polarity register, reset to active-low wiring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_inv_r <= 1'b1;
    end else if (cfg_valid) begin
      duty_inv_r <= cfg_data[0];
    end
  end

  assign cfg_ready = 1'b1;

  // Sequencer: accept, rate, product, divider digits, phase, table, brightness, output
  brd_ctrl #(
    .PHASE_BITS (PHASE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brd_dp #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_red         (in_tdata[7:0]),
    .in_green       (in_tdata[15:8]),
    .in_blue        (in_tdata[23:16]),
    .in_elapsed_us  (in_tdata[43:24]),
    .in_temp_deci_c (in_tdata[54:44]),
    .in_temp_valid  (in_tuser[0]),
    .duty_inv       (duty_inv_r),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_red_duty   (red_duty),
    .out_green_duty (green_duty),
    .out_blue_duty  (blue_duty)
  );

  assign out_tdata = {blue_duty, green_duty, red_duty};

endmodule
`default_nettype wire
